// File: rtl/tap_pkg.sv
// ---------------------------------------------------------------------------
// tap_pkg
// Shared widths, register indexes and constants for the two-axis attitude
// PID core and its port checker.
// ---------------------------------------------------------------------------
package tap_pkg;

  localparam int AXES      = 2;
  localparam int ANGLE_W   = 16;   // Q4.12
  localparam int ERR_W     = 17;
  localparam int GAIN_W    = 24;   // Q16.8
  localparam int PERIOD_W  = 16;   // Q0.16
  localparam int LIMIT_W   = 15;
  localparam int CMD_W     = 16;
  localparam int ACC_W     = 25;   // Q9.16
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int INTEGRATOR_LIMIT = 200;
  localparam int ACC_LIM          = INTEGRATOR_LIMIT * 65536;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd128;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd9600;

  localparam int AXIS_ROLL  = 0;
  localparam int AXIS_PITCH = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROLL_P   = 3'd0,
    CFG_ROLL_I   = 3'd1,
    CFG_ROLL_D   = 3'd2,
    CFG_PITCH_P  = 3'd3,
    CFG_PITCH_I  = 3'd4,
    CFG_PITCH_D  = 3'd5,
    CFG_PERIOD   = 3'd6,
    CFG_CMD_LIM  = 3'd7
  } cfg_idx_t;

endpackage

// File: rtl/two_axis_attitude_pid_core.sv
// Stages in order: input, error and products, integrators, I term, output.
// Throughput: one word per cycle when not stalled; the integrator add and
// clamp sits in one stage and is the only loop, so ticks can follow back
// to back. Stall on the output backs up through the five stage registers.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes both
// integrators and loads the register reset values.
// ---------------------------------------------------------------------------
// two_axis_attitude_pid_core
// Roll and pitch PID with clamped integrators, saturated commands and
// thrust pass-through.
// ---------------------------------------------------------------------------
module two_axis_attitude_pid_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic [tap_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tap_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  // input words
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_airborne,
  input  logic                                   in_restart,
  input  logic signed [tap_pkg::ANGLE_W-1:0]     in_roll_setpoint,
  input  logic signed [tap_pkg::ANGLE_W-1:0]     in_pitch_setpoint,
  input  logic signed [tap_pkg::ANGLE_W-1:0]     in_roll_angle,
  input  logic signed [tap_pkg::ANGLE_W-1:0]     in_pitch_angle,
  input  logic signed [tap_pkg::ANGLE_W-1:0]     in_roll_rate,
  input  logic signed [tap_pkg::ANGLE_W-1:0]     in_pitch_rate,
  input  logic signed [tap_pkg::CMD_W-1:0]       in_thrust_in,
  // result words
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tap_pkg::CMD_W-1:0]       out_roll_cmd,
  output logic signed [tap_pkg::CMD_W-1:0]       out_pitch_cmd,
  output logic signed [tap_pkg::CMD_W-1:0]       out_thrust_cmd
);

  localparam int NA    = tap_pkg::AXES;
  localparam int AW    = tap_pkg::ANGLE_W;
  localparam int EW    = tap_pkg::ERR_W;
  localparam int GW    = tap_pkg::GAIN_W;
  localparam int PW    = tap_pkg::PERIOD_W;
  localparam int LW    = tap_pkg::LIMIT_W;
  localparam int CW    = tap_pkg::CMD_W;
  localparam int ACW   = tap_pkg::ACC_W;
  localparam int INC_PROD_W = EW + PW + 1;      // err * unsigned period
  localparam int INC_W = INC_PROD_W - 12;       // after floor shift
  localparam int ASUM_W = ACW + 1;
  localparam int P_W   = GW + EW;
  localparam int D_W   = GW + AW;
  localparam int PD_W  = P_W + 1;
  localparam int I_W   = GW + ACW;
  localparam int TOT_W = I_W + 1;
  localparam int Q_W   = TOT_W - 24;

  localparam logic signed [ASUM_W-1:0] ACC_HI = ASUM_W'(tap_pkg::ACC_LIM);
  localparam logic signed [ASUM_W-1:0] ACC_LO = -ASUM_W'(tap_pkg::ACC_LIM);

  // ---------------- configuration registers
  logic signed [GW-1:0] kp_r [NA];
  logic signed [GW-1:0] ki_r [NA];
  logic signed [GW-1:0] kd_r [NA];
  logic [PW-1:0]        period_r;
  logic [LW-1:0]        lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        kp_r[a] <= '0;
        ki_r[a] <= '0;
        kd_r[a] <= '0;
      end
      period_r <= tap_pkg::PERIOD_RST;
      lim_r    <= tap_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (tap_pkg::cfg_idx_t'(cfg_index))
        tap_pkg::CFG_ROLL_P:  kp_r[tap_pkg::AXIS_ROLL]  <= cfg_wdata;
        tap_pkg::CFG_ROLL_I:  ki_r[tap_pkg::AXIS_ROLL]  <= cfg_wdata;
        tap_pkg::CFG_ROLL_D:  kd_r[tap_pkg::AXIS_ROLL]  <= cfg_wdata;
        tap_pkg::CFG_PITCH_P: kp_r[tap_pkg::AXIS_PITCH] <= cfg_wdata;
        tap_pkg::CFG_PITCH_I: ki_r[tap_pkg::AXIS_PITCH] <= cfg_wdata;
        tap_pkg::CFG_PITCH_D: kd_r[tap_pkg::AXIS_PITCH] <= cfg_wdata;
        tap_pkg::CFG_PERIOD:  period_r <= cfg_wdata[PW-1:0];
        tap_pkg::CFG_CMD_LIM: lim_r    <= cfg_wdata[LW-1:0];
      endcase
    end
  end

  // ---------------- pipeline control
  // vld_r[k] is stage k+1; stage 5 is the output register
  logic [4:0] vld_r;
  logic [4:0] adv;

  always_comb begin
    adv[4] = !vld_r[4] || !out_stall;
    for (int k = 3; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------- stage 1: input register
  logic                 s1_fly_r, s1_rst_r;
  logic signed [AW-1:0] s1_sp_r   [NA];
  logic signed [AW-1:0] s1_ang_r  [NA];
  logic signed [AW-1:0] s1_rate_r [NA];
  logic signed [CW-1:0] s1_thr_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_fly_r     <= in_airborne;
      s1_rst_r     <= in_restart;
      s1_sp_r[0]   <= in_roll_setpoint;
      s1_sp_r[1]   <= in_pitch_setpoint;
      s1_ang_r[0]  <= in_roll_angle;
      s1_ang_r[1]  <= in_pitch_angle;
      s1_rate_r[0] <= in_roll_rate;
      s1_rate_r[1] <= in_pitch_rate;
      s1_thr_r     <= in_thrust_in;
    end
  end

  // ---------------- stage 2: error and products
  logic signed [EW-1:0]         err      [NA];
  logic signed [INC_PROD_W-1:0] inc_prod [NA];
  logic signed [P_W-1:0]        p_prod   [NA];
  logic signed [D_W-1:0]        d_prod   [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      err[a]      = EW'(s1_sp_r[a]) - EW'(s1_ang_r[a]);
      inc_prod[a] = INC_PROD_W'(err[a]) * $signed({1'b0, period_r});
      p_prod[a]   = P_W'(kp_r[a]) * P_W'(err[a]);
      d_prod[a]   = D_W'(kd_r[a]) * D_W'(s1_rate_r[a]);
    end
  end

  logic                  s2_fly_r, s2_rst_r;
  logic signed [INC_W-1:0] s2_inc_r [NA];
  logic signed [P_W-1:0] s2_p_r   [NA];
  logic signed [D_W-1:0] s2_d_r   [NA];
  logic signed [CW-1:0]  s2_thr_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_fly_r <= s1_fly_r;
      s2_rst_r <= s1_rst_r;
      s2_thr_r <= s1_thr_r;
      for (int a = 0; a < NA; a++) begin
        // arithmetic shift gives the floor
        s2_inc_r[a] <= inc_prod[a][INC_PROD_W-1:12];
        s2_p_r[a]   <= p_prod[a];
        s2_d_r[a]   <= d_prod[a];
      end
    end
  end

  // ---------------- stage 3: integrators (the loop) and P - D
  logic signed [ACW-1:0]    acc_r   [NA];
  logic signed [ACW-1:0]    acc_nxt [NA];
  logic signed [ACW-1:0]    acc_base;
  logic signed [ASUM_W-1:0] acc_sum;

  always_comb begin
    acc_base = '0;
    acc_sum  = '0;
    for (int a = 0; a < NA; a++) begin
      acc_base = s2_rst_r ? '0 : acc_r[a];
      acc_sum  = ASUM_W'(acc_base) + ASUM_W'(s2_inc_r[a]);
      if (!s2_fly_r) begin
        acc_nxt[a] = '0;
      end else if (acc_sum > ACC_HI) begin
        acc_nxt[a] = ACW'(ACC_HI);
      end else if (acc_sum < ACC_LO) begin
        acc_nxt[a] = ACW'(ACC_LO);
      end else begin
        acc_nxt[a] = acc_sum[ACW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) acc_r[a] <= '0;
    end else if (vld_r[1] && adv[2]) begin
      for (int a = 0; a < NA; a++) acc_r[a] <= acc_nxt[a];
    end
  end

  // acc_r doubles as the stage 3 integrator value: it only moves when
  // stage 3 is reloaded
  logic signed [PD_W-1:0] s3_pd_r [NA];
  logic signed [CW-1:0]   s3_thr_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_thr_r <= s2_thr_r;
      for (int a = 0; a < NA; a++) begin
        s3_pd_r[a] <= PD_W'(s2_p_r[a]) - PD_W'(s2_d_r[a]);
      end
    end
  end

  // ---------------- stage 4: I term
  logic signed [I_W-1:0]  s4_i_r  [NA];
  logic signed [PD_W-1:0] s4_pd_r [NA];
  logic signed [CW-1:0]   s4_thr_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_thr_r <= s3_thr_r;
      for (int a = 0; a < NA; a++) begin
        s4_i_r[a]  <= I_W'(ki_r[a]) * I_W'(acc_r[a]);
        s4_pd_r[a] <= s3_pd_r[a];
      end
    end
  end

  // ---------------- stage 5: sum, truncate toward zero, saturate
  logic signed [TOT_W-1:0] tot  [NA];
  logic signed [Q_W-1:0]   quo  [NA];
  logic signed [CW-1:0]    cmd  [NA];
  logic signed [Q_W-1:0]   lim_q;
  logic signed [CW-1:0]    lim_c;
  logic signed [CW-1:0]    thr_c;

  always_comb begin
    lim_q = Q_W'($signed({1'b0, lim_r}));
    lim_c = $signed({1'b0, lim_r});
    for (int a = 0; a < NA; a++) begin
      tot[a] = TOT_W'($signed({s4_pd_r[a], 4'b0000})) + TOT_W'(s4_i_r[a]);
      quo[a] = tot[a][TOT_W-1:24];
      if (tot[a][TOT_W-1] && (|tot[a][23:0])) quo[a] = quo[a] + Q_W'(1);
      if (quo[a] > lim_q) begin
        cmd[a] = lim_c;
      end else if (quo[a] < -lim_q) begin
        cmd[a] = -lim_c;
      end else begin
        cmd[a] = quo[a][CW-1:0];
      end
    end
    if (s4_thr_r > lim_c) begin
      thr_c = lim_c;
    end else if (s4_thr_r < -lim_c) begin
      thr_c = -lim_c;
    end else begin
      thr_c = s4_thr_r;
    end
  end

  logic signed [CW-1:0] roll_r, pitch_r, thrust_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      roll_r   <= cmd[tap_pkg::AXIS_ROLL];
      pitch_r  <= cmd[tap_pkg::AXIS_PITCH];
      thrust_r <= thr_c;
    end
  end

  assign out_roll_cmd   = roll_r;
  assign out_pitch_cmd  = pitch_r;
  assign out_thrust_cmd = thrust_r;

endmodule

// File: rtl/tap_checker.sv
// ---------------------------------------------------------------------------
// tap_checker
// Port-level checks for the attitude PID core, bound into that module.
// ---------------------------------------------------------------------------
module tap_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [tap_pkg::CMD_W-1:0]    out_roll_cmd,
  input logic signed [tap_pkg::CMD_W-1:0]    out_pitch_cmd,
  input logic signed [tap_pkg::CMD_W-1:0]    out_thrust_cmd
);

  localparam logic signed [tap_pkg::CMD_W-1:0] CMD_MIN = {1'b1, {(tap_pkg::CMD_W-1){1'b0}}};

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // input side only backs up when every stage is full and output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // held result word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_roll_cmd)
      && $stable(out_pitch_cmd) && $stable(out_thrust_cmd))
    else $error("stalled result word changed");

  // limit is at most 15 bits, so the most negative code never appears
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_cmd != CMD_MIN && out_pitch_cmd != CMD_MIN
      && out_thrust_cmd != CMD_MIN)
    else $error("command outside saturation range");

endmodule

bind two_axis_attitude_pid_core tap_checker u_tap_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_roll_cmd   (out_roll_cmd),
  .out_pitch_cmd  (out_pitch_cmd),
  .out_thrust_cmd (out_thrust_cmd)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for two_axis_attitude_pid_core. A behavioural
// predictor keeps its own copy of the registers and both integrators and
// queues the expected command word for every accepted tick. Results are
// checked field by field as they leave the core. Stimulus is a short
// directed set, then random flight sequences over several register
// settings. Both sides idle at random, and one long output hold-off is
// included.
// ---------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_TICKS = 100;

  typedef struct {
    logic              fly;
    logic              restart;
    logic signed [15:0] roll_sp;
    logic signed [15:0] roll_ang;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_sp;
    logic signed [15:0] pitch_ang;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] thrust;
  } tick_t;

  typedef struct {
    logic signed [tap_pkg::CMD_W-1:0] roll;
    logic signed [tap_pkg::CMD_W-1:0] pitch;
    logic signed [tap_pkg::CMD_W-1:0] thrust;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                  cfg_we = 1'b0;
  logic [tap_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
  logic [tap_pkg::CFG_DATA_W-1:0]        cfg_wdata = '0;

  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic                                  in_airborne = 1'b0;
  logic                                  in_restart = 1'b0;
  logic signed [tap_pkg::ANGLE_W-1:0]    in_roll_setpoint = '0;
  logic signed [tap_pkg::ANGLE_W-1:0]    in_pitch_setpoint = '0;
  logic signed [tap_pkg::ANGLE_W-1:0]    in_roll_angle = '0;
  logic signed [tap_pkg::ANGLE_W-1:0]    in_pitch_angle = '0;
  logic signed [tap_pkg::ANGLE_W-1:0]    in_roll_rate = '0;
  logic signed [tap_pkg::ANGLE_W-1:0]    in_pitch_rate = '0;
  logic signed [tap_pkg::CMD_W-1:0]      in_thrust_in = '0;

  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic signed [tap_pkg::CMD_W-1:0]      out_roll_cmd;
  logic signed [tap_pkg::CMD_W-1:0]      out_pitch_cmd;
  logic signed [tap_pkg::CMD_W-1:0]      out_thrust_cmd;

  two_axis_attitude_pid_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [23:0]                      reg_shadow [8];
  logic signed [tap_pkg::ACC_W-1:0] roll_integ = '0;
  logic signed [tap_pkg::ACC_W-1:0] pitch_integ = '0;
  cmd_t                             pending_cmds [$];

  int fail_cnt = 0;
  int cycle_cnt = 0;

  // pacing
  int   gap_max = 0;
  int   burst_max = 1;
  int   burst_left = 0;
  int   stall_pct = 0;
  logic hold_tog = 1'b0;

  initial begin
    reg_shadow = '{default: 24'd0};
    reg_shadow[tap_pkg::CFG_PERIOD]  = 24'(tap_pkg::PERIOD_RST);
    reg_shadow[tap_pkg::CFG_CMD_LIM] = 24'(tap_pkg::LIMIT_RST);
  end

  // one axis: integrate, clamp, PID sum, truncate toward zero, saturate
  function automatic logic signed [tap_pkg::CMD_W-1:0] axis_cmd(
    inout logic signed [tap_pkg::ACC_W-1:0] integ,
    input logic                    fly,
    input logic signed [15:0]      sp,
    input logic signed [15:0]      ang,
    input logic signed [15:0]      rate,
    input logic [23:0]             kp_raw,
    input logic [23:0]             ki_raw,
    input logic [23:0]             kd_raw);
    longint err, acc, kp, ki, kd, period, lim, sum, q;
    err    = longint'(sp) - longint'(ang);
    kp     = longint'(signed'(kp_raw));
    ki     = longint'(signed'(ki_raw));
    kd     = longint'(signed'(kd_raw));
    period = longint'(reg_shadow[tap_pkg::CFG_PERIOD][15:0]);
    lim    = longint'(reg_shadow[tap_pkg::CFG_CMD_LIM][14:0]);
    if (fly) begin
      // arithmetic shift floors, as the Q9.16 increment requires
      acc = longint'(integ) + ((err * period) >>> 12);
      if (acc > tap_pkg::ACC_LIM)
        acc = tap_pkg::ACC_LIM;
      else if (acc < -tap_pkg::ACC_LIM)
        acc = -tap_pkg::ACC_LIM;
    end else begin
      acc = 0;
    end
    integ = acc[tap_pkg::ACC_W-1:0];
    sum = kp * err * 16 - kd * longint'(rate) * 16 + ki * acc;
    q = sum / 64'sd16777216;
    if (q > lim)
      q = lim;
    else if (q < -lim)
      q = -lim;
    return q[tap_pkg::CMD_W-1:0];
  endfunction

  function automatic tick_t make_tick(
    input logic fly, input logic restart,
    input logic signed [15:0] rsp, input logic signed [15:0] rang,
    input logic signed [15:0] rrate, input logic signed [15:0] psp,
    input logic signed [15:0] pang, input logic signed [15:0] prate,
    input logic signed [15:0] thrust);
    tick_t t;
    t.fly = fly;
    t.restart = restart;
    t.roll_sp = rsp;
    t.roll_ang = rang;
    t.roll_rate = rrate;
    t.pitch_sp = psp;
    t.pitch_ang = pang;
    t.pitch_rate = prate;
    t.thrust = thrust;
    return t;
  endfunction

  function automatic tick_t noise_tick();
    return make_tick(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
  endfunction

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(0, 3) == 0)
      return 16'($urandom);
    return 16'($urandom_range(0, 8192)) - 16'sd4096;
  endfunction

  function automatic logic [23:0] rand_gain();
    int          w;
    logic [23:0] v;
    unique case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      default: begin
        w = $urandom_range(1, 23);
        v = 24'($urandom) & ((24'd1 << w) - 24'd1);
        return ($urandom_range(0, 1) != 0) ? -v : v;
      end
    endcase
  endfunction

  task automatic set_pace(input int gap, input int burst, input int stall);
    gap_max = gap;
    burst_max = burst;
    burst_left = 0;
    stall_pct = stall;
  endtask

  // offer one tick word, wait for it to be taken, then predict its result
  task automatic send_tick(input tick_t t);
    int                 gap;
    cmd_t               want;
    logic signed [15:0] lim_s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_airborne       <= t.fly;
    in_restart        <= t.restart;
    in_roll_setpoint  <= t.roll_sp;
    in_roll_angle     <= t.roll_ang;
    in_roll_rate      <= t.roll_rate;
    in_pitch_setpoint <= t.pitch_sp;
    in_pitch_angle    <= t.pitch_ang;
    in_pitch_rate     <= t.pitch_rate;
    in_thrust_in      <= t.thrust;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);

    if (t.restart) begin
      roll_integ = '0;
      pitch_integ = '0;
    end
    want.roll = axis_cmd(roll_integ, t.fly, t.roll_sp, t.roll_ang, t.roll_rate,
                         reg_shadow[tap_pkg::CFG_ROLL_P],
                         reg_shadow[tap_pkg::CFG_ROLL_I],
                         reg_shadow[tap_pkg::CFG_ROLL_D]);
    want.pitch = axis_cmd(pitch_integ, t.fly, t.pitch_sp, t.pitch_ang, t.pitch_rate,
                          reg_shadow[tap_pkg::CFG_PITCH_P],
                          reg_shadow[tap_pkg::CFG_PITCH_I],
                          reg_shadow[tap_pkg::CFG_PITCH_D]);
    lim_s = $signed({1'b0, reg_shadow[tap_pkg::CFG_CMD_LIM][14:0]});
    if (t.thrust > lim_s)
      want.thrust = lim_s;
    else if (t.thrust < -lim_s)
      want.thrust = -lim_s;
    else
      want.thrust = t.thrust;
    pending_cmds.push_back(want);
  endtask

  // registers only change with the core drained
  task automatic write_config(
    input logic [23:0] rp, input logic [23:0] ri, input logic [23:0] rd,
    input logic [23:0] pp, input logic [23:0] pi_g, input logic [23:0] pd,
    input logic [23:0] period, input logic [23:0] limit);
    logic [23:0] vals [8];
    int          i;
    vals[tap_pkg::CFG_ROLL_P]  = rp;
    vals[tap_pkg::CFG_ROLL_I]  = ri;
    vals[tap_pkg::CFG_ROLL_D]  = rd;
    vals[tap_pkg::CFG_PITCH_P] = pp;
    vals[tap_pkg::CFG_PITCH_I] = pi_g;
    vals[tap_pkg::CFG_PITCH_D] = pd;
    vals[tap_pkg::CFG_PERIOD]  = period;
    vals[tap_pkg::CFG_CMD_LIM] = limit;
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_cmds.size() != 0) @(posedge clk);
    for (i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= tap_pkg::cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      unique case (tap_pkg::cfg_idx_t'(i))
        tap_pkg::CFG_PERIOD:  reg_shadow[i] = vals[i] & 24'h00FFFF;
        tap_pkg::CFG_CMD_LIM: reg_shadow[i] = vals[i] & 24'h007FFF;
        default:              reg_shadow[i] = vals[i];
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // reset values: gains zero, so only thrust saturation shows
  task automatic test_defaults();
    send_tick(make_tick(1, 0, 0, 0, 0, 0, 0, 0, 16'sh7FFF));
    send_tick(make_tick(1, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                        16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000));
    send_tick(make_tick(0, 1, 16'sd100, -16'sd100, 16'sd5, -16'sd7, 16'sd3, 16'sd9,
                        -16'sd9601));
  endtask

  task automatic test_extremes();
    write_config(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000,
                 24'h800000, 24'hFFFFFF, 24'hFFFFFF);
    send_tick(make_tick(1, 1, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                        16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
    send_tick(make_tick(1, 0, 16'sh8000, 16'sh7FFF, 16'sh8000,
                        16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
    send_tick(make_tick(1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 16'sh7FFF, 16'sh8000, 16'sh8000,
                        16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sd9600));
  endtask

  // unity I gain on roll, minus unity on pitch: the I term shows the integrator
  task automatic test_integrator_clamp();
    write_config(24'd0, 24'h000100, 24'd0, 24'd0, 24'hFFFF00, 24'd0,
                 24'h00FFFF, 24'h007FFF);
    repeat (13)
      send_tick(make_tick(1, 0, 16'sh7FFF, 16'sh8000, 0,
                          16'sh8000, 16'sh7FFF, 0, 0));
    send_tick(make_tick(1, 0, 16'sh8000, 16'sh7FFF, 0,
                        16'sh7FFF, 16'sh8000, 0, 0));
  endtask

  // period zero: integrators hold their wound-up value
  task automatic test_zero_period();
    write_config(24'd0, 24'h000100, 24'd0, 24'd0, 24'hFFFF00, 24'd0,
                 24'h000000, 24'h007FFF);
    send_tick(make_tick(1, 0, 16'sh7FFF, 16'sh8000, 0, 16'sh8000, 16'sh7FFF, 0, 0));
    send_tick(make_tick(1, 0, 16'sh8000, 16'sh7FFF, 0, 16'sh7FFF, 16'sh8000, 0, 0));
  endtask

  task automatic test_ground_restart();
    write_config(24'h000200, 24'h000100, 24'h000080, 24'hFFFE00, 24'hFFFF00,
                 24'h000040, 24'h00FFFF, 24'h007FFF);
    send_tick(make_tick(1, 0, 16'sd4000, -16'sd4000, 16'sd300,
                        -16'sd2000, 16'sd2000, -16'sd300, 16'sd50));
    send_tick(make_tick(1, 1, 16'sd4000, -16'sd4000, 16'sd300,
                        -16'sd2000, 16'sd2000, -16'sd300, 16'sd50));
    send_tick(make_tick(0, 1, 16'sd4000, -16'sd4000, 16'sd300,
                        -16'sd2000, 16'sd2000, -16'sd300, 16'sd50));
    send_tick(make_tick(0, 0, 16'sd4000, -16'sd4000, 16'sd300,
                        -16'sd2000, 16'sd2000, -16'sd300, 16'sd50));
  endtask

  task automatic test_zero_limit();
    write_config(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000,
                 24'h800000, 24'h00FFFF, 24'hFF8000);
    send_tick(make_tick(1, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                        16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
    send_tick(make_tick(1, 0, 16'sh8000, 16'sh7FFF, 16'sh8000,
                        16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
  endtask

  // mostly well-formed flights: restart, then steady setpoints with a
  // biased error so the integrators wind up; the rest is noise
  task automatic test_random_flights();
    tick_t             t;
    int                phase, sent, seq_len, k, bias_r, bias_p, err;
    logic signed [15:0] sp_r, sp_p;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_config(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000,
                        24'h800000, 24'hFFFFFF, 24'hFFFFFF);
        1: write_config(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                        24'h7FFFFF, 24'h000001, 24'h000001);
        default: write_config(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                              rand_gain(), rand_gain(), 24'($urandom),
                              24'($urandom));
      endcase
      case (phase % 4)
        0: set_pace(0, 1, 0);
        1: set_pace(3, 8, 30);
        2: set_pace(8, 3, 60);
        default: set_pace(1, 20, 10);
      endcase
      sent = 0;
      while (sent < PHASE_TICKS) begin
        seq_len = $urandom_range(4, 30);
        if ($urandom_range(0, 99) < 85) begin
          sp_r = rand_angle();
          sp_p = rand_angle();
          bias_r = $urandom_range(0, 4096) - 2048;
          bias_p = $urandom_range(0, 4096) - 2048;
          for (k = 0; k < seq_len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
              sp_r = rand_angle();
              sp_p = rand_angle();
            end
            t.fly = ($urandom_range(0, 19) != 0);
            t.restart = (k == 0) || ($urandom_range(0, 49) == 0);
            err = bias_r + $urandom_range(0, 512) - 256;
            t.roll_sp = sp_r;
            t.roll_ang = sp_r - 16'(err);
            t.roll_rate = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                          : 16'($urandom_range(0, 4096)) - 16'sd2048;
            err = bias_p + $urandom_range(0, 512) - 256;
            t.pitch_sp = sp_p;
            t.pitch_ang = sp_p - 16'(err);
            t.pitch_rate = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                           : 16'($urandom_range(0, 4096)) - 16'sd2048;
            t.thrust = 16'($urandom);
            send_tick(t);
            sent++;
          end
        end else begin
          for (k = 0; k < seq_len; k++) begin
            send_tick(noise_tick());
            sent++;
          end
        end
      end
    end
  endtask

  // output held off for a long stretch while ticks keep coming
  task automatic test_backpressure();
    set_pace(0, 1, 0);
    hold_tog <= ~hold_tog;
    repeat (40) send_tick(noise_tick());
  endtask

  // receiver: random stall pattern, plus the long hold when requested
  always @(posedge clk) begin : out_stall_gen
    int   hold_left;
    logic hold_seen;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_seen = hold_tog;
    end else if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_cmds
    cmd_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_cmds.size() == 0) begin
        $error("result word with no tick outstanding");
        fail_cnt++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_roll_cmd !== want.roll) begin
          $error("roll_cmd: expected %0d, got %0d", want.roll, out_roll_cmd);
          fail_cnt++;
        end
        if (out_pitch_cmd !== want.pitch) begin
          $error("pitch_cmd: expected %0d, got %0d", want.pitch, out_pitch_cmd);
          fail_cnt++;
        end
        if (out_thrust_cmd !== want.thrust) begin
          $error("thrust_cmd: expected %0d, got %0d", want.thrust, out_thrust_cmd);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_integrator_clamp();
    test_zero_period();
    test_ground_restart();
    test_zero_limit();
    test_random_flights();
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
